@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`endif

@@ rtl/hop_pkg.sv @@
// types, command codes and helpers of the hot offset profiler
`default_nettype none

package hop_pkg;

    localparam int CNT_W    = 32;
    localparam int POS_W    = 32;
    localparam int CHOSEN_W = 31;

    typedef logic [CNT_W-1:0]        t_count;
    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [CHOSEN_W-1:0]     t_chosen;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // add that sticks at all ones
    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/hot_offset_profiler_unit.sv @@
// hot offset profiler: position table in a synchronous memory, one entry read per cycle
`default_nettype none

// A request is taken when start is high and busy is low. It scans the used entries of the
// position table, one per cycle through the single memory read port, updating a matching
// entry in place, then for a record appends a new position or adds to the untracked total,
// and finally checks whether the largest count holds at least 80 percent of all hits. The
// result is on the o_ result ports for exactly one cycle with o_result_valid high and cannot
// be held off; busy is already low in that cycle. Empty entries are tracked by a fill count,
// so no clearing pass runs after reset.
module hot_offset_profiler_unit #(
    parameter int TRACKED_ENTRIES = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_cmd,
    input  wire hop_pkg::t_pos   i_position,
    input  wire hop_pkg::t_count i_hit_count,
    output logic                 o_result_valid,
    output logic                 o_recorded,
    output logic                 o_choice_valid,
    output hop_pkg::t_chosen     o_chosen_position
);
    import hop_pkg::*;

    `include "assert_macros.svh"

    localparam int IW = (TRACKED_ENTRIES > 1) ? $clog2(TRACKED_ENTRIES) : 1;
    localparam int FW = $clog2(TRACKED_ENTRIES + 1);
    // sum of all entries plus untracked
    localparam int TW = CNT_W + $clog2(TRACKED_ENTRIES + 1);
    localparam int CW = TW + 3;
    localparam int MW = POS_W + CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;

    logic [MW-1:0]    r_mem [TRACKED_ENTRIES];
    logic [MW-1:0]    r_rd_data;

    logic [2:0]       r_state;
    logic [FW-1:0]    r_fill;
    logic [IW-1:0]    r_idx;
    logic             r_started;
    t_count           r_untracked;

    logic             r_cmd;
    logic [POS_W-1:0] r_pos;
    t_count           r_cnt;
    logic             r_matched;
    logic             r_rec;
    t_count           r_best;
    t_chosen          r_best_pos;
    logic [TW-1:0]    r_total;

    logic             r_out_valid;
    logic             r_out_rec;
    logic             r_out_choice;
    t_chosen          r_out_pos;

    logic             accept;
    logic [POS_W-1:0] ent_pos;
    t_count           ent_hits;
    logic             ent_hit;
    t_count           n_hits;
    logic [FW-1:0]    idx_next;
    logic             scan_last;
    logic             fill_new;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [MW-1:0]    wdata;
    logic [CW-1:0]    lhs;
    logic [CW-1:0]    rhs;
    logic             n_choice;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign ent_pos   = r_rd_data[MW-1:CNT_W];
    assign ent_hits  = r_rd_data[CNT_W-1:0];
    // stored positions are never negative, so a negative request never matches
    assign ent_hit   = (r_cmd == CMD_RECORD) && (ent_pos == r_pos);
    assign n_hits    = ent_hit ? sat_add(ent_hits, r_cnt) : ent_hits;
    assign idx_next  = FW'(r_idx) + FW'(1);
    assign scan_last = (idx_next == r_fill);
    assign fill_new  = (r_cmd == CMD_RECORD) && !r_matched && !r_pos[POS_W-1]
                       && (r_fill < FW'(TRACKED_ENTRIES));

    assign rd_en   = accept || ((r_state == S_SCAN) && !scan_last);
    assign rd_addr = (r_state == S_IDLE) ? '0 : IW'(idx_next);

    assign we    = ((r_state == S_SCAN) && ent_hit) || ((r_state == S_FINAL) && fill_new);
    assign waddr = (r_state == S_SCAN) ? r_idx : IW'(r_fill);
    assign wdata = (r_state == S_SCAN) ? {ent_pos, n_hits} : {r_pos, r_cnt};

    // best * 10 against total * 8
    assign lhs      = CW'({r_best, 3'b000}) + CW'({r_best, 1'b0});
    assign rhs      = {r_total, 3'b000};
    assign n_choice = r_started && (r_best != '0) && (lhs >= rhs);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_untracked <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= '0;
                        if (i_cmd == CMD_RECORD) begin
                            r_started <= 1'b1;
                        end
                        r_state <= (r_fill == '0) ? S_FINAL : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_last) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_idx <= IW'(idx_next);
                    end
                end
                S_FINAL: begin
                    if (fill_new) begin
                        r_fill <= r_fill + FW'(1);
                    end else if ((r_cmd == CMD_RECORD) && !r_matched) begin
                        r_untracked <= sat_add(r_untracked, r_cnt);
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request payload and scan accumulators
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd      <= i_cmd;
                    r_pos      <= i_position;
                    r_cnt      <= i_hit_count;
                    r_matched  <= 1'b0;
                    r_best     <= '0;
                    r_best_pos <= '0;
                    r_total    <= '0;
                end
            end
            S_SCAN: begin
                if (ent_hit) begin
                    r_matched <= 1'b1;
                end
                if (n_hits > r_best) begin
                    r_best     <= n_hits;
                    r_best_pos <= ent_pos[CHOSEN_W-1:0];
                end
                r_total <= r_total + TW'(n_hits);
            end
            S_FINAL: begin
                r_rec <= r_matched || fill_new;
                if (fill_new) begin
                    if (r_cnt > r_best) begin
                        r_best     <= r_cnt;
                        r_best_pos <= r_pos[CHOSEN_W-1:0];
                    end
                    r_total <= r_total + TW'(r_cnt);
                end
            end
            S_SUM: begin
                r_total <= r_total + TW'(r_untracked);
            end
            S_CMP: begin
                r_out_rec    <= r_rec;
                r_out_choice <= n_choice;
                r_out_pos    <= n_choice ? r_best_pos : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid    = r_out_valid;
    assign o_recorded        = r_out_rec;
    assign o_choice_valid    = r_out_choice;
    assign o_chosen_position = r_out_pos;

    `ASSERT_IMPLIES(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `ASSERT_IMPLIES(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(TRACKED_ENTRIES))
    `ASSERT_IMPLIES(a_no_choice_zero, i_clk, i_rst_n, o_result_valid && !o_choice_valid, o_chosen_position == '0)

endmodule

`default_nettype wire

@@ sim/tb_hot_offset_profiler_unit.sv @@
// self-checking testbench for the hot offset profiler: directed, random and saturation runs
`timescale 1ns / 1ps

module tb_hot_offset_profiler_unit;
    import hop_pkg::*;

    localparam int ENTRIES    = 4;
    localparam int MAX_SHOWN  = 10;
    localparam int PHASE_REQS = 630;

    typedef struct packed {
        logic    recorded;
        logic    choice_valid;
        t_chosen chosen;
    } t_report;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    logic    i_cmd;
    t_pos    i_position;
    t_count  i_hit_count;
    logic    o_result_valid;
    logic    o_recorded;
    logic    o_choice_valid;
    t_chosen o_chosen_position;

    // shadow of the profile table
    t_count  slot_pos [ENTRIES];
    t_count  slot_hits[ENTRIES];
    t_count  spill_hits;
    logic    seen_record;

    t_report pending_reports[$];
    int      mismatches;
    int      idle_pct;

    hot_offset_profiler_unit #(.TRACKED_ENTRIES(ENTRIES)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_position        (i_position),
        .i_hit_count       (i_hit_count),
        .o_result_valid    (o_result_valid),
        .o_recorded        (o_recorded),
        .o_choice_valid    (o_choice_valid),
        .o_chosen_position (o_chosen_position)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_count clamped_add(input t_count a, input t_count b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // applies one request to the shadow table and returns the report it should produce
    function automatic t_report profile_step(input logic cmd, input t_pos pos, input t_count cnt);
        t_report     r;
        logic        placed;
        logic        stop;
        t_count      best;
        t_count      best_pos;
        logic [63:0] total;
        r = '0;
        if (cmd == CMD_RECORD) begin
            seen_record = 1'b1;
            placed = 1'b0;
            if (!pos[POS_W-1]) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!placed && slot_pos[i] == t_count'(pos)) begin
                        slot_hits[i] = clamped_add(slot_hits[i], cnt);
                        placed = 1'b1;
                    end else if (!placed && slot_pos[i] == '1) begin
                        slot_pos[i]  = t_count'(pos);
                        slot_hits[i] = cnt;
                        placed = 1'b1;
                    end
                end
            end
            if (!placed)
                spill_hits = clamped_add(spill_hits, cnt);
            r.recorded = placed;
        end
        if (seen_record) begin
            stop = 1'b0;
            best = '0;
            best_pos = '0;
            total = '0;
            // table fills in order, so the first empty entry ends the used part
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_pos[i][CNT_W-1])
                    stop = 1'b1;
                if (!stop) begin
                    if (slot_hits[i] > best) begin
                        best = slot_hits[i];
                        best_pos = slot_pos[i];
                    end
                    total = total + 64'(slot_hits[i]);
                end
            end
            total = total + 64'(spill_hits);
            if (best != '0 && 64'(best) * 64'd10 >= total * 64'd8) begin
                r.choice_valid = 1'b1;
                r.chosen = best_pos[CHOSEN_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic sender_pause();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // start stays high after acceptance so back-to-back requests need no extra edge
    task automatic send_request(input logic cmd, input t_pos pos, input t_count cnt);
        sender_pause();
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_position  <= pos;
        i_hit_count <= cnt;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_reports.push_back(profile_step(cmd, pos, cnt));
    endtask

    task automatic wait_all_reports();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic test_query_before_record();
        send_request(CMD_QUERY, '1, '1);
        send_request(CMD_QUERY, '0, '0);
        send_request(CMD_QUERY, 32'sh7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_table_fill();
        send_request(CMD_RECORD, 32'sd0, 32'd0);           // started but all counts zero
        send_request(CMD_QUERY, 32'sd0, 32'd9);
        send_request(CMD_RECORD, 32'sd0, 32'd5);
        send_request(CMD_RECORD, 32'sh8000_0000, 32'd1);   // negative goes untracked
        send_request(CMD_RECORD, -32'sd1, 32'd1);          // all ones is negative too
        send_request(CMD_RECORD, 32'sh7FFF_FFFF, 32'd3);
        send_request(CMD_RECORD, 32'sh7FFF_FFFF, 32'd40);
        send_request(CMD_RECORD, 32'sh1234_5678, 32'd0);
        send_request(CMD_RECORD, 32'sh5555_5555, 32'd1);
        send_request(CMD_RECORD, 32'sh2AAA_AAAA, 32'd1);   // table full
        send_request(CMD_RECORD, 32'sd0, 32'd1);
        send_request(CMD_QUERY, 32'sh2AAA_AAAA, 32'h5555_5555);
        wait_all_reports();
    endtask

    task automatic test_random_mix(input int count);
        int   hot;
        int   sel;
        t_pos pos;
        hot = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 2)
                hot = $urandom_range(ENTRIES - 1);
            sel = $urandom_range(99);
            if (sel < 55) begin
                send_request(CMD_RECORD, t_pos'(slot_pos[hot]), t_count'($urandom_range(63)));
            end else if (sel < 70) begin
                send_request(CMD_RECORD, t_pos'(slot_pos[$urandom_range(ENTRIES - 1)]),
                             t_count'($urandom_range(15)));
            end else if (sel < 80) begin
                pos = t_pos'($urandom);
                send_request(CMD_RECORD, pos, t_count'($urandom_range(7)));
            end else if (sel < 95) begin
                send_request(CMD_QUERY, t_pos'($urandom), t_count'($urandom));
            end else begin
                send_request(CMD_RECORD, t_pos'($urandom), '0);
            end
        end
    endtask

    task automatic test_counter_saturation();
        send_request(CMD_RECORD, t_pos'(slot_pos[2]), '1);
        send_request(CMD_RECORD, t_pos'(slot_pos[2]), '1);
        send_request(CMD_QUERY, '0, '1);
        send_request(CMD_RECORD, 32'sh8000_0001, 32'hFFFF_FFF0);
        send_request(CMD_RECORD, -32'sd2, '1);
        send_request(CMD_RECORD, t_pos'(slot_pos[1]), '1);
        send_request(CMD_RECORD, t_pos'(slot_pos[1]), 32'h0000_0001);
        send_request(CMD_QUERY, '1, '0);
        for (int n = 0; n < 30; n++)
            send_request(logic'($urandom_range(1)), t_pos'($urandom), t_count'($urandom));
    endtask

    always @(posedge i_clk) begin : check_results
        t_report got;
        t_report want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            got = '{o_recorded, o_choice_valid, o_chosen_position};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result rec=%b valid=%b pos=%h",
                             $realtime, got.recorded, got.choice_valid, got.chosen);
            end else begin
                want = pending_reports.pop_front();
                if (got.recorded !== want.recorded || got.choice_valid !== want.choice_valid
                        || got.chosen !== want.chosen) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: expected rec=%b valid=%b pos=%h, got rec=%b valid=%b pos=%h",
                                 $realtime, want.recorded, want.choice_valid, want.chosen,
                                 got.recorded, got.choice_valid, got.chosen);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL hot_offset_profiler_unit");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= CMD_QUERY;
        i_position  <= '0;
        i_hit_count <= '0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_pos[i]  = '1;
            slot_hits[i] = '0;
        end
        spill_hits  = '0;
        seen_record = 1'b0;
        mismatches  = 0;
        idle_pct    = 14;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_query_before_record();
        test_table_fill();
        test_random_mix(PHASE_REQS);
        // hold off until the profiler has answered every request
        wait_all_reports();
        idle_pct = 61;
        test_random_mix(PHASE_REQS);
        idle_pct = 0;
        test_random_mix(PHASE_REQS);
        test_counter_saturation();

        start <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (pending_reports.size() != 0)
            $display("%0d requests never answered", pending_reports.size());
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("PASS hot_offset_profiler_unit");
        end else begin
            $display("FAIL hot_offset_profiler_unit");
        end
        $finish;
    end

endmodule
